// File: rtl/fgut_pkg.sv
// ----------------------------------------------------------------------------
// fgut_pkg
// Shared types and constants for the friend group union tracker.
// ----------------------------------------------------------------------------
package fgut_pkg;

  localparam int ID_W             = 15;
  localparam int MEMBER_SLOTS_DEF = 32768;
  localparam int CFG_ADDR_W       = 3;
  localparam int CFG_DATA_W       = 32;

  localparam logic [ID_W-1:0] SIZE_MAX      = 15'h7fff;
  localparam logic [ID_W-1:0] PEOPLE_RESET  = 15'h7fff;
  localparam logic [ID_W-1:0] LARGEST_RESET = 15'd1;

  // Register index, taken from paddr[2]
  localparam logic [0:0] REG_PEOPLE_IN_USE = 1'b0;

  typedef struct packed {
    logic [ID_W-1:0] member_a;
    logic [ID_W-1:0] member_b;
  } in_beat_t;

  typedef struct packed {
    logic            were_already_friends;
    logic [ID_W-1:0] largest_group;
  } out_beat_t;

  typedef struct packed {
    logic [ID_W-1:0] sum;
    logic [ID_W-1:0] largest;
  } alu_res_t;

endpackage

// File: rtl/fgut_alu.sv
// ----------------------------------------------------------------------------
// fgut_alu
// Shared saturating adder for group counts with running-maximum compare.
// ----------------------------------------------------------------------------
module fgut_alu (
  input  logic [fgut_pkg::ID_W-1:0] op_a,
  input  logic [fgut_pkg::ID_W-1:0] op_b,
  input  logic [fgut_pkg::ID_W-1:0] largest,
  output fgut_pkg::alu_res_t        res
);

  logic [fgut_pkg::ID_W:0]   sum_full;
  logic [fgut_pkg::ID_W-1:0] sum_sat;

  assign sum_full = {1'b0, op_a} + {1'b0, op_b};
  // Saturate at the 15-bit maximum
  assign sum_sat  = sum_full[fgut_pkg::ID_W] ? fgut_pkg::SIZE_MAX
                                              : sum_full[fgut_pkg::ID_W-1:0];

  assign res.sum     = sum_sat;
  assign res.largest = (sum_sat > largest) ? sum_sat : largest;

endmodule

// File: rtl/friend_group_union_tracker.sv
// ----------------------------------------------------------------------------
// friend_group_union_tracker
// Joins member pairs into groups and reports the largest group so far.
// ----------------------------------------------------------------------------
// One item is handled at a time. After reset the block sweeps both stores
// (one entry per cycle) before it takes its first beat. A merge of two groups
// relabels members 1 to min(people_in_use, MEMBER_SLOTS-1) one per cycle
// through the single leader-store read port. Each item waits for the result
// register to drain before its result is written.
// ----------------------------------------------------------------------------
module friend_group_union_tracker #(
  parameter int MEMBER_SLOTS = fgut_pkg::MEMBER_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  fgut_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fgut_pkg::out_beat_t                 out_data,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [fgut_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [fgut_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [fgut_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int          IDX_W     = $clog2(MEMBER_SLOTS);
  localparam int          W         = fgut_pkg::ID_W;
  localparam logic [16:0] SLOTS17   = 17'(MEMBER_SLOTS);
  localparam logic [16:0] LAST_ID17 = 17'(MEMBER_SLOTS - 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MEMBER_SLOTS - 1);
  localparam logic [IDX_W-1:0] ONE_IDX  = IDX_W'(1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_B,
    S_DECIDE,
    S_NEW_B,
    S_JOIN_WR,
    S_MG_RD_B,
    S_MG_SUM,
    S_MG_CLR,
    S_SCAN,
    S_SCAN_END,
    S_RESULT
  } state_t;

  function automatic logic [IDX_W-1:0] to_addr(input logic [W-1:0] id);
    to_addr = IDX_W'(17'(id));
  endfunction

  // Stores
  logic [W-1:0] leader_mem [MEMBER_SLOTS];
  logic [W-1:0] size_mem   [MEMBER_SLOTS];

  logic             ld_we, sz_we;
  logic [IDX_W-1:0] ld_waddr, ld_raddr, sz_waddr, sz_raddr;
  logic [W-1:0]     ld_wdata, sz_wdata;
  logic [W-1:0]     ld_rdata_r, sz_rdata_r;

  // Control and payload registers
  state_t              state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  fgut_pkg::out_beat_t out_data_r, out_data_nxt;
  logic [W-1:0]        largest_r, largest_nxt;
  logic [W-1:0]        people_r, people_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                pend_r, pend_nxt;
  logic [IDX_W-1:0]    pend_addr_r, pend_addr_nxt;
  logic [IDX_W-1:0]    last_r, last_nxt;
  logic [W-1:0]        a_r, a_nxt, b_r, b_nxt;
  logic [W-1:0]        la_r, la_nxt, lb_r, lb_nxt;
  logic [W-1:0]        sza_r, sza_nxt;
  logic                friends_r, friends_nxt;

  // Shared adder
  logic [W-1:0]       alu_a, alu_b;
  fgut_pkg::alu_res_t alu_res;

  logic        cfg_wr;
  logic        ids_ok;
  logic [16:0] last17;

  fgut_alu u_alu (
    .op_a    (alu_a),
    .op_b    (alu_b),
    .largest (largest_r),
    .res     (alu_res)
  );

  always_ff @(posedge clk) begin
    if (ld_we) begin
      leader_mem[ld_waddr] <= ld_wdata;
    end
    ld_rdata_r <= leader_mem[ld_raddr];
  end

  always_ff @(posedge clk) begin
    if (sz_we) begin
      size_mem[sz_waddr] <= sz_wdata;
    end
    sz_rdata_r <= size_mem[sz_raddr];
  end

  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2:2] == fgut_pkg::REG_PEOPLE_IN_USE) ?
                      fgut_pkg::CFG_DATA_W'(people_r) : '0;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ids_ok = (in_data.member_a != '0) && (in_data.member_b != '0) &&
                  (17'(in_data.member_a) < SLOTS17) &&
                  (17'(in_data.member_b) < SLOTS17);

  assign last17 = (17'(people_r) > LAST_ID17) ? LAST_ID17 : 17'(people_r);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    largest_nxt   = largest_r;
    people_nxt    = people_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    last_nxt      = last_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    la_nxt        = la_r;
    lb_nxt        = lb_r;
    sza_nxt       = sza_r;
    friends_nxt   = friends_r;

    ld_we    = 1'b0;
    ld_waddr = to_addr(a_r);
    ld_wdata = '0;
    ld_raddr = to_addr(a_r);
    sz_we    = 1'b0;
    sz_waddr = to_addr(la_r);
    sz_wdata = '0;
    sz_raddr = to_addr(la_r);
    alu_a    = sz_rdata_r;
    alu_b    = '0;

    if (cfg_wr && (cfg_paddr[2:2] == fgut_pkg::REG_PEOPLE_IN_USE)) begin
      people_nxt = cfg_pwdata[W-1:0];
    end

    // Drop the result once it is taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        ld_we    = 1'b1;
        ld_waddr = idx_r;
        sz_we    = 1'b1;
        sz_waddr = idx_r;
        idx_nxt  = idx_r + ONE_IDX;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        ld_raddr = to_addr(in_data.member_a);
        if (in_valid) begin
          a_nxt       = in_data.member_a;
          b_nxt       = in_data.member_b;
          friends_nxt = 1'b0;
          state_nxt   = ids_ok ? S_RD_B : S_RESULT;
        end
      end
      S_RD_B: begin
        la_nxt    = ld_rdata_r;
        ld_raddr  = to_addr(b_r);
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        lb_nxt = ld_rdata_r;
        priority if (a_r == b_r) begin
          friends_nxt = (la_r != '0);
          state_nxt   = S_RESULT;
        end else if ((la_r == '0) && (ld_rdata_r == '0)) begin
          // New group of two led by member_a
          ld_we       = 1'b1;
          ld_waddr    = to_addr(a_r);
          ld_wdata    = a_r;
          alu_a       = W'(2);
          alu_b       = '0;
          sz_we       = 1'b1;
          sz_waddr    = to_addr(a_r);
          sz_wdata    = alu_res.sum;
          largest_nxt = alu_res.largest;
          state_nxt   = S_NEW_B;
        end else if ((la_r == '0) || (ld_rdata_r == '0)) begin
          // One member joins the other's group; hold the leader in lb
          lb_nxt    = (la_r == '0) ? ld_rdata_r : la_r;
          ld_we     = 1'b1;
          ld_waddr  = (la_r == '0) ? to_addr(a_r) : to_addr(b_r);
          ld_wdata  = (la_r == '0) ? ld_rdata_r : la_r;
          sz_raddr  = (la_r == '0) ? to_addr(ld_rdata_r) : to_addr(la_r);
          state_nxt = S_JOIN_WR;
        end else if (la_r == ld_rdata_r) begin
          friends_nxt = 1'b1;
          state_nxt   = S_RESULT;
        end else begin
          sz_raddr  = to_addr(la_r);
          state_nxt = S_MG_RD_B;
        end
      end
      S_NEW_B: begin
        ld_we     = 1'b1;
        ld_waddr  = to_addr(b_r);
        ld_wdata  = a_r;
        state_nxt = S_RESULT;
      end
      S_JOIN_WR: begin
        alu_a       = sz_rdata_r;
        alu_b       = W'(1);
        sz_we       = 1'b1;
        sz_waddr    = to_addr(lb_r);
        sz_wdata    = alu_res.sum;
        largest_nxt = alu_res.largest;
        state_nxt   = S_RESULT;
      end
      S_MG_RD_B: begin
        sza_nxt   = sz_rdata_r;
        sz_raddr  = to_addr(lb_r);
        state_nxt = S_MG_SUM;
      end
      S_MG_SUM: begin
        alu_a       = sza_r;
        alu_b       = sz_rdata_r;
        sz_we       = 1'b1;
        sz_waddr    = to_addr(la_r);
        sz_wdata    = alu_res.sum;
        largest_nxt = alu_res.largest;
        state_nxt   = S_MG_CLR;
      end
      S_MG_CLR: begin
        sz_we    = 1'b1;
        sz_waddr = to_addr(lb_r);
        sz_wdata = '0;
        idx_nxt  = ONE_IDX;
        last_nxt = IDX_W'(last17);
        pend_nxt = 1'b0;
        state_nxt = (last17 == '0) ? S_RESULT : S_SCAN;
      end
      S_SCAN: begin
        // Read one member per cycle, relabel the one read last cycle
        ld_raddr      = idx_r;
        pend_nxt      = 1'b1;
        pend_addr_nxt = idx_r;
        if (pend_r && (ld_rdata_r == lb_r)) begin
          ld_we    = 1'b1;
          ld_waddr = pend_addr_r;
          ld_wdata = la_r;
        end
        idx_nxt = idx_r + ONE_IDX;
        if (idx_r == last_r) begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        if (pend_r && (ld_rdata_r == lb_r)) begin
          ld_we    = 1'b1;
          ld_waddr = pend_addr_r;
          ld_wdata = la_r;
        end
        pend_nxt  = 1'b0;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.were_already_friends = friends_r;
          out_data_nxt.largest_group        = largest_r;
          out_valid_nxt                     = 1'b1;
          state_nxt                         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
      largest_r   <= fgut_pkg::LARGEST_RESET;
      people_r    <= fgut_pkg::PEOPLE_RESET;
      idx_r       <= '0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      largest_r   <= largest_nxt;
      people_r    <= people_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
    end
    out_data_r  <= out_data_nxt;
    pend_addr_r <= pend_addr_nxt;
    last_r      <= last_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    la_r        <= la_nxt;
    lb_r        <= lb_nxt;
    sza_r       <= sza_nxt;
    friends_r   <= friends_nxt;
  end

endmodule

// File: rtl/fgut_checker.sv
// ----------------------------------------------------------------------------
// fgut_checker
// Port-level checks for the friend group union tracker.
// ----------------------------------------------------------------------------
module fgut_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input fgut_pkg::out_beat_t out_data
);

  // The store sweep holds off input right after reset
  a_stall_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  // One item at a time: busy after each accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while item in flight");

  // A result only appears while an item is being worked on
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no item in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

endmodule

bind friend_group_union_tracker fgut_checker u_fgut_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
